// ----- src/sh24_pkg.sv -----
// ----------------------------------------------------------------------------
// sh24_pkg: shared types, constants and round function
// Holds the command passed from the front end to the round engine, the
// SipHash state type, the key schedule and the SipRound itself.
// ----------------------------------------------------------------------------
package sh24_pkg;

  localparam int unsigned WORD_W     = 64;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned LEN_W      = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b1;

  // Initialization vectors
  localparam logic [WORD_W-1:0] IV0 = 64'h736f6d6570736575;
  localparam logic [WORD_W-1:0] IV1 = 64'h646f72616e646f6d;
  localparam logic [WORD_W-1:0] IV2 = 64'h6c7967656e657261;
  localparam logic [WORD_W-1:0] IV3 = 64'h7465646279746573;

  // Constant folded into v2 before the finalization rounds
  localparam logic [WORD_W-1:0] FINAL_XOR = 64'h00000000000000ff;

  // Full-word byte count
  localparam logic [COUNT_W-1:0] FULL_COUNT = 4'd8;

  typedef struct packed {
    logic [WORD_W-1:0] v0;
    logic [WORD_W-1:0] v1;
    logic [WORD_W-1:0] v2;
    logic [WORD_W-1:0] v3;
  } sip_state_t;

  // One queued command: an optional full-word absorb and an optional
  // finalization with its closing block.
  typedef struct packed {
    logic              start;     // load state from key first
    logic              full;      // absorb word as a full block
    logic              finalize;  // close message with final_blk
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] final_blk;
  } cmd_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                             input int unsigned r);
    rotl = (x << r) | (x >> (WORD_W - r));
  endfunction

  function automatic sip_state_t sip_round(input sip_state_t s);
    logic [WORD_W-1:0] a, b, c, d;
    a = s.v0; b = s.v1; c = s.v2; d = s.v3;
    a = a + b; b = rotl(b, 13); b = b ^ a; a = rotl(a, 32);
    c = c + d; d = rotl(d, 16); d = d ^ c;
    a = a + d; d = rotl(d, 21); d = d ^ a;
    c = c + b; b = rotl(b, 17); b = b ^ c; c = rotl(c, 32);
    sip_round = '{v0: a, v1: b, v2: c, v3: d};
  endfunction

  function automatic sip_state_t init_state(input logic [WORD_W-1:0] k0,
                                            input logic [WORD_W-1:0] k1);
    init_state = '{v0: k0 ^ IV0, v1: k1 ^ IV1, v2: k0 ^ IV2, v3: k1 ^ IV3};
  endfunction

endpackage

// ----- src/siphash_2_4_keyed_hash.sv -----
// ----------------------------------------------------------------------------
// siphash_2_4_keyed_hash: keyed SipHash-2-4 engine, 64-bit result
// A classifier takes message beats into a short command queue and a round
// engine works the queue off, one SipRound per cycle except while it takes
// a command or waits to hand out a hash. A word that is not last gets
// COMPRESSION_ROUNDS rounds, and words that follow back to back chain without
// a pass through idle; the last beat of a message gets compression rounds for
// its closing block (after those for the word itself when the last word is
// full), then FINAL_ROUNDS rounds before the hash is registered. Input beats
// are taken while the queue has room, also while a hash waits at the output.
// The key registers are sampled when the engine takes a message's first beat.
// ----------------------------------------------------------------------------
module siphash_2_4_keyed_hash #(
  parameter int unsigned COMPRESSION_ROUNDS = 2,
  parameter int unsigned FINAL_ROUNDS       = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [sh24_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sh24_pkg::WORD_W-1:0]    cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [sh24_pkg::WORD_W-1:0]    in_data_word,
  input  logic [sh24_pkg::COUNT_W-1:0]   in_byte_count,
  input  logic                           in_last,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sh24_pkg::WORD_W-1:0]    out_hash
);

  logic [sh24_pkg::WORD_W-1:0] key_low_r, key_low_nxt;
  logic [sh24_pkg::WORD_W-1:0] key_high_r, key_high_nxt;
  logic                        push;
  sh24_pkg::cmd_t              push_cmd;
  logic                        q_full;
  logic                        pop;
  logic                        cmd_valid;
  sh24_pkg::cmd_t              cmd;

  // Key registers
  always_comb begin
    key_low_nxt  = key_low_r;
    key_high_nxt = key_high_r;
    if (cfg_we) begin
      unique case (cfg_index)
        sh24_pkg::REG_KEY_LOW:  key_low_nxt  = cfg_wdata;
        sh24_pkg::REG_KEY_HIGH: key_high_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
    end else begin
      key_low_r  <= key_low_nxt;
      key_high_r <= key_high_nxt;
    end
  end

  sh24_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_word  (in_data_word),
    .in_byte_count (in_byte_count),
    .in_last       (in_last),
    .push          (push),
    .push_cmd      (push_cmd),
    .q_full        (q_full)
  );

  sh24_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  sh24_back #(
    .COMPRESSION_ROUNDS (COMPRESSION_ROUNDS),
    .FINAL_ROUNDS       (FINAL_ROUNDS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .key_low   (key_low_r),
    .key_high  (key_high_r),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_hash  (out_hash)
  );

endmodule

// ----- src/sh24_front.sv -----
// ----------------------------------------------------------------------------
// sh24_front: input classifier
// Accepts message beats, tracks message start and length, masks the partial
// bytes and builds the closing block, then pushes one command per beat.
// ----------------------------------------------------------------------------
module sh24_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sh24_pkg::WORD_W-1:0]   in_data_word,
  input  logic [sh24_pkg::COUNT_W-1:0]  in_byte_count,
  input  logic                          in_last,
  output logic                          push,
  output sh24_pkg::cmd_t                push_cmd,
  input  logic                          q_full
);

  localparam int unsigned PART_BYTES = sh24_pkg::WORD_W / 8 - 1;

  logic                         in_msg_r, in_msg_nxt;
  logic [sh24_pkg::LEN_W-1:0]   len_r, len_nxt;
  logic                         start;
  logic                         full;
  logic [sh24_pkg::LEN_W-1:0]   len_base;
  logic [sh24_pkg::LEN_W-1:0]   len_new;
  logic [sh24_pkg::WORD_W-9:0]  partial;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  // Classify the beat
  always_comb begin
    start    = !in_msg_r;
    full     = !in_last || (in_byte_count >= sh24_pkg::FULL_COUNT);
    len_base = start ? '0 : len_r;
    len_new  = full ? len_base + sh24_pkg::LEN_W'(sh24_pkg::FULL_COUNT)
                    : len_base + sh24_pkg::LEN_W'(in_byte_count);
    // keep only the bytes below the count; none when the word goes in whole
    for (int i = 0; i < PART_BYTES; i++) begin
      partial[8*i +: 8] = (!full && (in_byte_count > sh24_pkg::COUNT_W'(i))) ?
                          in_data_word[8*i +: 8] : 8'h00;
    end
    push_cmd.start     = start;
    push_cmd.full      = full;
    push_cmd.finalize  = in_last;
    push_cmd.word      = in_data_word;
    push_cmd.final_blk = {len_new, partial};
    in_msg_nxt         = push ? !in_last : in_msg_r;
    len_nxt            = push ? len_new : len_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_msg_r <= 1'b0;
      len_r    <= '0;
    end else begin
      in_msg_r <= in_msg_nxt;
      len_r    <= len_nxt;
    end
  end

endmodule

// ----- src/sh24_queue.sv -----
// ----------------------------------------------------------------------------
// sh24_queue: command queue
// Short first-word-fall-through queue between the classifier and the round
// engine so that each side can stall on its own.
// ----------------------------------------------------------------------------
module sh24_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sh24_pkg::cmd_t  push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            cmd_valid,
  output sh24_pkg::cmd_t  cmd
);

  localparam int unsigned DEPTH = sh24_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  sh24_pkg::cmd_t    mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_pop;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = mem[rd_ptr_r];
  assign do_pop    = pop && cmd_valid;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CNT_W'(push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- src/sh24_back.sv -----
// ----------------------------------------------------------------------------
// sh24_back: round engine
// One SipRound per cycle unless loading or holding a hash: compression rounds
// for each absorbed block, then the finalization rounds and the hash output.
// ----------------------------------------------------------------------------
module sh24_back #(
  parameter int unsigned COMPRESSION_ROUNDS = 2,
  parameter int unsigned FINAL_ROUNDS       = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [sh24_pkg::WORD_W-1:0]  key_low,
  input  logic [sh24_pkg::WORD_W-1:0]  key_high,
  input  logic                         cmd_valid,
  input  sh24_pkg::cmd_t               cmd,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [sh24_pkg::WORD_W-1:0]  out_hash
);

  localparam int unsigned MAX_ROUNDS =
    (COMPRESSION_ROUNDS > FINAL_ROUNDS) ? COMPRESSION_ROUNDS : FINAL_ROUNDS;
  localparam int unsigned RCNT_W = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1;

  typedef enum logic [1:0] {S_IDLE, S_COMP, S_FIN, S_DONE} state_t;

  state_t                       state_r, state_nxt;
  sh24_pkg::sip_state_t         v_r, v_nxt;
  sh24_pkg::sip_state_t         rnd;
  sh24_pkg::sip_state_t         after;
  sh24_pkg::sip_state_t         ld_base;
  logic [RCNT_W-1:0]            cnt_r, cnt_nxt;
  logic [sh24_pkg::WORD_W-1:0]  m_r, m_nxt;
  logic [sh24_pkg::WORD_W-1:0]  fblk_r, fblk_nxt;
  logic                         fin_r, fin_nxt;
  logic                         last_blk_r, last_blk_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [sh24_pkg::WORD_W-1:0]  hash_r, hash_nxt;
  logic                         do_load;

  assign out_valid = out_valid_r;
  assign out_hash  = hash_r;

  // Next-state logic
  always_comb begin
    rnd           = sh24_pkg::sip_round(v_r);
    after         = rnd;
    ld_base       = v_r;
    do_load       = 1'b0;
    pop           = 1'b0;
    state_nxt     = state_r;
    v_nxt         = v_r;
    cnt_nxt       = cnt_r;
    m_nxt         = m_r;
    fblk_nxt      = fblk_r;
    fin_nxt       = fin_r;
    last_blk_nxt  = last_blk_r;
    hash_nxt      = hash_r;
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          do_load = 1'b1;
          ld_base = v_r;
        end
      end
      S_COMP: begin
        if (cnt_r == RCNT_W'(COMPRESSION_ROUNDS - 1)) begin
          after.v0 = rnd.v0 ^ m_r;
          cnt_nxt  = '0;
          priority if (last_blk_r) begin
            // closing block done: start finalization
            after.v2  = after.v2 ^ sh24_pkg::FINAL_XOR;
            v_nxt     = after;
            state_nxt = S_FIN;
          end else if (fin_r) begin
            // full word done: absorb the closing block next
            after.v3     = after.v3 ^ fblk_r;
            v_nxt        = after;
            m_nxt        = fblk_r;
            last_blk_nxt = 1'b1;
          end else if (cmd_valid && !cmd.start) begin
            // chain straight into the next queued command of the message
            do_load = 1'b1;
            ld_base = after;
          end else begin
            v_nxt     = after;
            state_nxt = S_IDLE;
          end
        end else begin
          v_nxt   = rnd;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FIN: begin
        v_nxt = rnd;
        if (cnt_r == RCNT_W'(FINAL_ROUNDS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          hash_nxt      = v_r.v0 ^ v_r.v1 ^ v_r.v2 ^ v_r.v3;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Take a command: optional key load, then fold in the first block
    if (do_load) begin
      pop = 1'b1;
      if (cmd.start) begin
        ld_base = sh24_pkg::init_state(key_low, key_high);
      end
      if (cmd.full) begin
        ld_base.v3   = ld_base.v3 ^ cmd.word;
        m_nxt        = cmd.word;
        last_blk_nxt = 1'b0;
      end else begin
        ld_base.v3   = ld_base.v3 ^ cmd.final_blk;
        m_nxt        = cmd.final_blk;
        last_blk_nxt = 1'b1;
      end
      v_nxt     = ld_base;
      fin_nxt   = cmd.finalize;
      fblk_nxt  = cmd.final_blk;
      cnt_nxt   = '0;
      state_nxt = S_COMP;
    end
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    v_r        <= v_nxt;
    m_r        <= m_nxt;
    fblk_r     <= fblk_nxt;
    fin_r      <= fin_nxt;
    last_blk_r <= last_blk_nxt;
    hash_r     <= hash_nxt;
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for siphash_2_4_keyed_hash
// Streams message beats through the valid/ready input and works out each
// expected hash with a SipHash-2-4 predictor kept inside the bench. Covers
// short tails, odd byte counts, key changes between messages and inside an
// open message, and many random messages, with random stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned COMP_ROUNDS = 2;
  localparam int unsigned FIN_ROUNDS  = 4;
  localparam int          DRAIN_CYCLES = 40;
  localparam realtime     RUN_LIMIT    = 5ms;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [sh24_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [sh24_pkg::WORD_W-1:0]    cfg_wdata;
  logic                           in_valid;
  logic                           in_ready;
  logic [sh24_pkg::WORD_W-1:0]    in_data_word;
  logic [sh24_pkg::COUNT_W-1:0]   in_byte_count;
  logic                           in_last;
  logic                           out_valid;
  logic                           out_ready;
  logic [sh24_pkg::WORD_W-1:0]    out_hash;

  siphash_2_4_keyed_hash #(
    .COMPRESSION_ROUNDS(COMP_ROUNDS),
    .FINAL_ROUNDS      (FIN_ROUNDS)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_word (in_data_word),
    .in_byte_count(in_byte_count),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_hash     (out_hash)
  );

  // Predictor state: key copy, running SipHash words, length byte
  logic [sh24_pkg::WORD_W-1:0] key_lo_m;
  logic [sh24_pkg::WORD_W-1:0] key_hi_m;
  logic [sh24_pkg::WORD_W-1:0] hv [4];
  logic [sh24_pkg::LEN_W-1:0]  msg_len_b;
  bit                          msg_open;

  logic [sh24_pkg::WORD_W-1:0] hash_expect_q [$];

  int  beats_sent;
  int  msgs_closed;
  int  hashes_checked;
  int  longest_msg;
  int  cur_msg_words;
  int  mismatches;
  bit  src_steady;
  bit  sink_steady;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog
  initial begin
    #RUN_LIMIT;
    $display("timeout with %0d hashes still pending", hash_expect_q.size());
    $display("testbench failed");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic [sh24_pkg::WORD_W-1:0] rol64(
      input logic [sh24_pkg::WORD_W-1:0] x,
      input int unsigned n);
    return (x << n) | (x >> (sh24_pkg::WORD_W - n));
  endfunction

  task automatic sip_mix();
    logic [sh24_pkg::WORD_W-1:0] a, b, c, d;
    a = hv[0]; b = hv[1]; c = hv[2]; d = hv[3];
    a = a + b; b = rol64(b, 13); b = b ^ a; a = rol64(a, 32);
    c = c + d; d = rol64(d, 16); d = d ^ c;
    a = a + d; d = rol64(d, 21); d = d ^ a;
    c = c + b; b = rol64(b, 17); b = b ^ c; c = rol64(c, 32);
    hv[0] = a; hv[1] = b; hv[2] = c; hv[3] = d;
  endtask

  task automatic sip_absorb(input logic [sh24_pkg::WORD_W-1:0] m);
    hv[3] = hv[3] ^ m;
    repeat (COMP_ROUNDS) sip_mix();
    hv[0] = hv[0] ^ m;
  endtask

  // Advance the hash state by one accepted beat; queue a hash on the last one
  task automatic sip_predict_beat(input logic [sh24_pkg::WORD_W-1:0] w,
                                  input logic [sh24_pkg::COUNT_W-1:0] cnt,
                                  input logic lst);
    logic [sh24_pkg::WORD_W-1:0] tail;
    tail = '0;
    if (!msg_open) begin
      hv[0] = key_lo_m ^ sh24_pkg::IV0;
      hv[1] = key_hi_m ^ sh24_pkg::IV1;
      hv[2] = key_lo_m ^ sh24_pkg::IV2;
      hv[3] = key_hi_m ^ sh24_pkg::IV3;
      msg_len_b = '0;
      msg_open = 1'b1;
      cur_msg_words = 0;
    end
    cur_msg_words++;
    if (!lst) begin
      sip_absorb(w);
      msg_len_b = msg_len_b + sh24_pkg::LEN_W'(8);
    end else begin
      // counts of 8 and above close with a full word first
      if (cnt >= sh24_pkg::FULL_COUNT) begin
        sip_absorb(w);
        msg_len_b = msg_len_b + sh24_pkg::LEN_W'(8);
      end else begin
        tail = w & ((64'd1 << (8 * cnt)) - 64'd1);
        msg_len_b = msg_len_b + sh24_pkg::LEN_W'(cnt);
      end
      sip_absorb({msg_len_b, 56'd0} | tail);
      hv[2] = hv[2] ^ sh24_pkg::FINAL_XOR;
      repeat (FIN_ROUNDS) sip_mix();
      hash_expect_q.push_back(hv[0] ^ hv[1] ^ hv[2] ^ hv[3]);
      msg_open = 1'b0;
      msgs_closed++;
      if (cur_msg_words > longest_msg) longest_msg = cur_msg_words;
    end
  endtask

  // ------------------------------------------------------------------ helpers
  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [sh24_pkg::WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Send one beat and wait for the handshake
  task automatic send_beat(input logic [sh24_pkg::WORD_W-1:0] w,
                           input logic [sh24_pkg::COUNT_W-1:0] cnt,
                           input logic lst);
    int gap;
    gap = src_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_word  <= w;
    in_byte_count <= cnt;
    in_last       <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sip_predict_beat(w, cnt, lst);
    beats_sent++;
  endtask

  // Drop valid, let every pending hash come out, then let the engine settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (hash_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Both key halves, one register per cycle
  task automatic write_key(input logic [sh24_pkg::WORD_W-1:0] lo,
                           input logic [sh24_pkg::WORD_W-1:0] hi);
    cfg_we    <= 1'b1;
    cfg_index <= sh24_pkg::REG_KEY_LOW;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= sh24_pkg::REG_KEY_HIGH;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    key_lo_m = lo;
    key_hi_m = hi;
  endtask

  // ------------------------------------------------------------ result check
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (hash_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected hash %h with nothing pending", out_hash);
      end else begin
        if (out_hash !== hash_expect_q[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("hash mismatch: expected %h got %h", hash_expect_q[0], out_hash);
        end
        void'(hash_expect_q.pop_front());
        hashes_checked++;
      end
    end
  end

  // Result side backpressure
  initial begin
    int g;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      if (sink_steady) begin
        @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 6)) @(posedge clk);
        g = pick_gap();
        if (g > 0) begin
          out_ready <= 1'b0;
          repeat (g) @(posedge clk);
        end
      end
    end
  end

  // -------------------------------------------------------------------- tests
  // Reset key of zero, empty and short messages
  task automatic test_reset_key();
    send_beat('0, 4'd0, 1'b1);
    send_beat(rand_word(), 4'd3, 1'b1);
    wait_idle();
  endtask

  // Single-beat messages across the byte counts, incl. counts above 8
  task automatic test_tail_counts();
    write_key(64'h0706050403020100, 64'h0f0e0d0c0b0a0908);
    send_beat('0, 4'd0, 1'b1);
    send_beat('1, 4'd1, 1'b1);
    send_beat('1, 4'd3, 1'b1);
    send_beat('1, 4'd7, 1'b1);
    send_beat('1, 4'd8, 1'b1);
    send_beat('0, 4'd8, 1'b1);
    send_beat(rand_word(), 4'd9, 1'b1);
    send_beat(rand_word(), 4'd15, 1'b1);
    wait_idle();
  endtask

  // Counts on non-last beats are ignored
  task automatic test_multi_word();
    send_beat('1, 4'd0, 1'b0);
    send_beat(rand_word(), 4'd4, 1'b1);
    send_beat('0, 4'd15, 1'b0);
    send_beat(rand_word(), 4'd8, 1'b0);
    send_beat('1, 4'd8, 1'b1);
    wait_idle();
  endtask

  // All-ones key
  task automatic test_key_extremes();
    write_key('1, '1);
    send_beat('1, 4'd2, 1'b0);
    send_beat('1, 4'd0, 1'b1);
    wait_idle();
  endtask

  // New key written while a message is open applies to the next message only
  task automatic test_key_mid_message();
    write_key(rand_word(), rand_word());
    send_beat(rand_word(), 4'd8, 1'b0);
    send_beat(rand_word(), 4'd1, 1'b0);
    wait_idle();
    write_key(rand_word(), rand_word());
    send_beat(rand_word(), 4'd5, 1'b1);
    send_beat(rand_word(), 4'd6, 1'b1);
    wait_idle();
  endtask

  // Random messages under one key; the first one runs past 256 bytes
  task automatic test_random_messages(input logic [sh24_pkg::WORD_W-1:0] lo,
                                      input logic [sh24_pkg::WORD_W-1:0] hi,
                                      input int budget);
    int start_beats;
    int body;
    int r;
    bit first;
    logic [sh24_pkg::WORD_W-1:0] w;
    logic [sh24_pkg::COUNT_W-1:0] cnt;
    write_key(lo, hi);
    start_beats = beats_sent;
    first = 1'b1;
    while (beats_sent - start_beats < budget) begin
      r = $urandom_range(0, 99);
      if (first) body = $urandom_range(33, 40);
      else if (r < 85) body = $urandom_range(0, 6);
      else if (r < 97) body = $urandom_range(7, 20);
      else body = $urandom_range(33, 45);
      first = 1'b0;
      src_steady  = ($urandom_range(0, 7) == 0);
      sink_steady = ($urandom_range(0, 7) == 0);
      for (int i = 0; i < body; i++)
        send_beat(rand_word(), 4'($urandom_range(0, 15)), 1'b0);
      // last beat: mostly legal counts, sometimes over-range
      r = $urandom_range(0, 9);
      cnt = (r < 7) ? 4'($urandom_range(0, 8)) : 4'($urandom_range(0, 15));
      r = $urandom_range(0, 9);
      w = (r == 0) ? '0 : (r == 1) ? '1 : rand_word();
      send_beat(w, cnt, 1'b1);
    end
    src_steady  = 1'b0;
    sink_steady = 1'b0;
    wait_idle();
  endtask

  // --------------------------------------------------------------------- main
  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= sh24_pkg::REG_KEY_LOW;
    cfg_wdata     <= '0;
    in_valid      <= 1'b0;
    in_data_word  <= '0;
    in_byte_count <= '0;
    in_last       <= 1'b0;
    key_lo_m = '0;
    key_hi_m = '0;
    msg_len_b = '0;
    msg_open = 1'b0;
    for (int i = 0; i < 4; i++) hv[i] = '0;
    beats_sent = 0;
    msgs_closed = 0;
    hashes_checked = 0;
    longest_msg = 0;
    cur_msg_words = 0;
    mismatches = 0;
    src_steady = 1'b0;
    sink_steady = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_key();
    test_tail_counts();
    test_multi_word();
    test_key_extremes();
    test_key_mid_message();
    test_random_messages(rand_word(), rand_word(), 110);
    test_random_messages('1, '0, 110);
    test_random_messages('0, rand_word(), 110);
    test_random_messages(rand_word(), '1, 110);

    if (hash_expect_q.size() != 0) mismatches++;
    $display("sent %0d beats in %0d messages (longest %0d words), checked %0d hashes",
             beats_sent, msgs_closed, longest_msg, hashes_checked);
    $display("nine key settings, byte counts 0 to 15, key change inside a message; %0d errors",
             mismatches);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
